>>> sv/rlep_pkg.sv
// Package for the RGB LED effect PWM driver: field widths, mode and
// register index codes, FSM state type. No dependencies.
`default_nettype none

package rlep_pkg;

  localparam int PHASE_W = 25;   // phase counter and effect period
  localparam int CFG_W   = 24;   // widest configuration register
  localparam int DUTY_W  = 16;   // PWM compare value
  localparam int LEVEL_W = 8;    // color level per channel
  localparam int NUM_CH  = 3;    // red, green, blue

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Configuration register indexes
  localparam logic [2:0] REG_EFFECT_MODE  = 3'd0;
  localparam logic [2:0] REG_COMMON_ANODE = 3'd1;
  localparam logic [2:0] REG_COLOR_RGB    = 3'd2;
  localparam logic [2:0] REG_BREATH_PER   = 3'd3;
  localparam logic [2:0] REG_FLASH_ON     = 3'd4;
  localparam logic [2:0] REG_FLASH_OFF    = 3'd5;
  localparam logic [2:0] REG_MAX_DUTY     = 3'd6;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [DUTY_W-1:0]  duty_t;
  typedef level_t [NUM_CH-1:0] rgb_level_t;   // index 0 is red
  typedef duty_t  [NUM_CH-1:0] rgb_duty_t;    // index 0 is red

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_STATIC,
    MODE_BREATH,
    MODE_FLASH
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a tick
    ST_MOD,     // phase modulo period
    ST_IDX,     // breath table index
    ST_SCALE,   // level to compare value
    ST_HOLD     // result waits for the output register
  } state_t;

endpackage

`default_nettype wire

>>> sv/rlep_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used for phase modulo period and for the breath index.
`default_nettype none

module rlep_serial_div #(
  parameter int DW = 33,   // dividend / quotient width
  parameter int VW = 25    // divisor / remainder width
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,    // nonzero, stable while busy
  output logic               done,       // one-cycle pulse, results valid
  output logic [DW-1:0]      quotient,
  output logic [VW-1:0]      remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] num;
  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [VW:0]   sh;
  logic [VW:0]   diff;
  logic          ge;

  always_comb begin
    sh   = {rem, num[DW-1]};
    ge   = (sh >= {1'b0, divisor});
    diff = sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (start) begin
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      num <= {num[DW-2:0], ge};
      rem <= ge ? diff[VW-1:0] : sh[VW-1:0];
    end
  end

  assign quotient  = num;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> sv/rlep_duty_scale.sv
// Maps three 8-bit levels to PWM compare values: bit-serial level*duty_top,
// then /255 by reciprocal shift-add, then optional common-anode inversion.
// Depends on rlep_pkg.
`default_nettype none

module rlep_duty_scale
  import rlep_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire rgb_level_t level,
  input  wire duty_t      duty_top,
  input  wire logic       common_anode,
  output logic            done,
  output rgb_duty_t       compare
);

  localparam int ACC_W       = LEVEL_W + DUTY_W;
  localparam int RECIP_SHIFT = 32;
  localparam int SUM_W       = ACC_W + 26;
  localparam int CNT_W       = $clog2(LEVEL_W + 2);

  level_t [NUM_CH-1:0]    lvl_sh;
  logic [NUM_CH-1:0][ACC_W-1:0] acc;
  logic [ACC_W-1:0]       md_sh;
  logic [CNT_W-1:0]       cnt;
  logic [NUM_CH-1:0][SUM_W-1:0] sum;
  rgb_duty_t              quot;
  rgb_duty_t              result;

  // floor(x/255) = (x * (2^24 + 2^16 + 2^8 + 2)) >> 32, exact for x < 255*2^16
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = {2'b0, acc[c], 24'b0} + {10'b0, acc[c], 16'b0}
             + {18'b0, acc[c], 8'b0} + {25'b0, acc[c], 1'b0};
      quot[c]   = sum[c][RECIP_SHIFT +: DUTY_W];
      result[c] = common_anode ? (duty_top - quot[c]) : quot[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(LEVEL_W + 1);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lvl_sh <= level;
      md_sh  <= {{(ACC_W - DUTY_W){1'b0}}, duty_top};
      for (int c = 0; c < NUM_CH; c++) begin
        acc[c] <= '0;
      end
    end else if (cnt > CNT_W'(1)) begin
      // one level bit per cycle, LSB first
      for (int c = 0; c < NUM_CH; c++) begin
        acc[c]    <= acc[c] + (lvl_sh[c][0] ? md_sh : '0);
        lvl_sh[c] <= {1'b0, lvl_sh[c][LEVEL_W-1:1]};
      end
      md_sh <= {md_sh[ACC_W-2:0], 1'b0};
    end else if (cnt == CNT_W'(1)) begin
      compare <= result;
    end
  end

endmodule

`default_nettype wire

>>> sv/rgb_led_effect_pwm_driver.sv
// RGB LED effect generator, top level: config registers, tick sequencer,
// breath table. Depends on rlep_pkg, rlep_serial_div, rlep_duty_scale.
//
// Usage:
//  - s_axis: one transaction per millisecond tick; s_axis_tdata[0] is the
//    restart flag, which zeroes the effect phase before the tick is used.
//  - m_axis: one transaction per tick carrying the red, green and blue
//    PWM compare values.
//  - cfg_we/cfg_index/cfg_data: register writes, taken at any edge with
//    cfg_we high; write only while no tick is in flight.
//  - From accept to m_axis_tvalid: off/static run only the bit-serial scaler;
//    flash first runs one pass of the bit-serial divider (DIV_W = 25 +
//    clog2(BREATH_STEPS) bits wide) for phase modulo period, breath adds a
//    second pass for the breath index; the scaler result then goes to the
//    output register.
//  - Ticks are taken one at a time; s_axis_tready is high only while the
//    sequencer is idle, which it returns to once the result sits in the
//    output register, so a new tick is taken while m_axis waits.
//  - If the receiver stalls, the finished result waits in the scaler
//    until the output register frees up; nothing is dropped.
//  - Reset (synchronous) loads register defaults, clears phase and m_axis_tvalid.
`default_nettype none

module rgb_led_effect_pwm_driver
  import rlep_pkg::*;
#(
  parameter int BREATH_STEPS = 256   // breath table length, 16..4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // tick input
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,    // [0] restart
  // compare output
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [47:0]           m_axis_tdata,    // [15:0] red, [31:16] green, [47:32] blue
  // configuration writes
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W    = $clog2(BREATH_STEPS);
  localparam int DIV_W    = PHASE_W + IDX_W;
  localparam int LUT_HALF = BREATH_STEPS / 2;

  // Breath table build, decimal fixed point with 18 fractional digits.
  localparam logic signed [127:0] LUT_ONE = 128'sd1000000000000000000;
  localparam logic signed [127:0] LUT_TWO = 128'sd2000000000000000000;
  localparam logic signed [127:0] LUT_PI  = 128'sd3141592653589793238;

  typedef level_t lut_t [BREATH_STEPS];

  // level[j] = floor(255*(1 - cos(2*pi*j/N))/2); cosines by Chebyshev
  // recurrence up to a quarter turn, reflected past it; upper half by exact mirror symmetry
  function automatic lut_t build_breath_lut();
    logic signed [127:0] y, y2, y4, y6, y8, y10, y12, y14, y16;
    logic signed [127:0] cos_step, c_prev, c_cur, c_next, lvl;
    logic signed [127:0] cos_tab [LUT_HALF + 1];
    lut_t lut;
    int m;
    y   = LUT_PI / BREATH_STEPS;
    y2  = (y * y) / LUT_ONE;
    y4  = (y2 * y2) / LUT_ONE;
    y6  = (y4 * y2) / LUT_ONE;
    y8  = (y6 * y2) / LUT_ONE;
    y10 = (y8 * y2) / LUT_ONE;
    y12 = (y10 * y2) / LUT_ONE;
    y14 = (y12 * y2) / LUT_ONE;
    y16 = (y14 * y2) / LUT_ONE;
    cos_step = LUT_ONE - y2 / 128'sd2 + y4 / 128'sd24 - y6 / 128'sd720
             + y8 / 128'sd40320 - y10 / 128'sd3628800 + y12 / 128'sd479001600
             - y14 / 128'sd87178291200 + y16 / 128'sd20922789888000;
    c_prev = LUT_ONE;
    c_cur  = cos_step;
    cos_tab[0] = LUT_ONE;
    for (int k = 1; k <= LUT_HALF; k++) begin
      cos_tab[k] = c_cur;
      c_next = (128'sd2 * cos_step * c_cur) / LUT_ONE - c_prev;
      c_prev = c_cur;
      c_cur  = c_next;
    end
    for (int j = 0; j < BREATH_STEPS; j++) begin
      m = (2 * j <= BREATH_STEPS) ? 2 * j : 2 * (BREATH_STEPS - j);
      if (2 * m <= BREATH_STEPS) begin
        lvl = (128'sd255 * (LUT_ONE - cos_tab[m])) / LUT_TWO;
      end else if (m == BREATH_STEPS) begin
        lvl = 128'sd255;
      end else begin
        lvl = 128'sd254 - (128'sd255 * (LUT_ONE - cos_tab[BREATH_STEPS - m])) / LUT_TWO;
      end
      lut[j] = lvl[LEVEL_W-1:0];
    end
    return lut;
  endfunction

  localparam lut_t BREATH_LUT = build_breath_lut();

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  mode_t                effect_mode;
  logic                 common_anode;
  logic [CFG_W-1:0]     color_rgb;
  logic [CFG_W-1:0]     breath_period;
  logic [CFG_W-1:0]     flash_on_ticks;
  logic [CFG_W-1:0]     flash_off_ticks;
  duty_t                duty_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode     <= MODE_OFF;
      common_anode    <= 1'b0;
      color_rgb       <= '0;
      breath_period   <= CFG_W'(1000);
      flash_on_ticks  <= CFG_W'(500);
      flash_off_ticks <= CFG_W'(500);
      duty_top        <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EFFECT_MODE:  effect_mode     <= mode_t'(cfg_data[1:0]);
        REG_COMMON_ANODE: common_anode    <= cfg_data[0];
        REG_COLOR_RGB:    color_rgb       <= cfg_data;
        REG_BREATH_PER:   breath_period   <= cfg_data;
        REG_FLASH_ON:     flash_on_ticks  <= cfg_data;
        REG_FLASH_OFF:    flash_off_ticks <= cfg_data;
        REG_MAX_DUTY:     duty_top        <= cfg_data[DUTY_W-1:0];
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Effect period and color
  // ---------------------------------------------------------------------
  logic [PHASE_W-1:0] flash_period;
  logic [PHASE_W-1:0] period_raw;
  logic [PHASE_W-1:0] period;
  rgb_level_t         color_lvl;

  always_comb begin
    flash_period = {1'b0, flash_on_ticks} + {1'b0, flash_off_ticks};
    period_raw   = (effect_mode == MODE_BREATH) ? {1'b0, breath_period} : flash_period;
    // a zero period behaves as one tick
    period       = (period_raw == '0) ? PHASE_W'(1) : period_raw;
    color_lvl[CH_RED]   = color_rgb[23:16];
    color_lvl[CH_GREEN] = color_rgb[15:8];
    color_lvl[CH_BLUE]  = color_rgb[7:0];
  end

  // ---------------------------------------------------------------------
  // Datapath units
  // ---------------------------------------------------------------------
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [PHASE_W-1:0] div_rem;

  rlep_serial_div #(
    .DW (DIV_W),
    .VW (PHASE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (period),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  logic       scale_start;
  rgb_level_t scale_level;
  logic       scale_done;
  rgb_duty_t  scale_cmp;

  rlep_duty_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .start        (scale_start),
    .level        (scale_level),
    .duty_top     (duty_top),
    .common_anode (common_anode),
    .done         (scale_done),
    .compare      (scale_cmp)
  );

  // ---------------------------------------------------------------------
  // Tick sequencer
  // ---------------------------------------------------------------------
  state_t             state;
  state_t             state_next;
  logic [PHASE_W-1:0] phase;
  logic               phase_load;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] eff_inc;
  logic               lit;
  logic               out_free;
  logic               out_load;
  level_t             breath_lvl;

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign eff_inc       = div_rem + PHASE_W'(1);       // div_rem is the phase mod period
  assign lit           = ({1'b0, flash_on_ticks} > div_rem);
  assign breath_lvl    = BREATH_LUT[div_quot[IDX_W-1:0]];

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    scale_start  = 1'b0;
    scale_level  = '0;
    phase_load   = 1'b0;
    phase_next   = '0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (effect_mode == MODE_OFF || effect_mode == MODE_STATIC) begin
            // phase parks at zero outside breath and flash
            phase_load  = 1'b1;
            scale_start = 1'b1;
            scale_level = (effect_mode == MODE_STATIC) ? color_lvl : '0;
            state_next  = ST_SCALE;
          end else begin
            div_start    = 1'b1;
            div_dividend = s_axis_tdata[0] ? '0 : DIV_W'(phase);
            state_next   = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (div_done) begin
          phase_load = 1'b1;
          phase_next = (eff_inc == period) ? '0 : eff_inc;
          if (effect_mode == MODE_BREATH) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(div_rem) * DIV_W'(BREATH_STEPS);
            state_next   = ST_IDX;
          end else begin
            scale_start = 1'b1;
            scale_level = lit ? color_lvl : '0;
            state_next  = ST_SCALE;
          end
        end
      end
      ST_IDX: begin
        if (div_done) begin
          scale_start = 1'b1;
          scale_level = {NUM_CH{breath_lvl}};
          state_next  = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
    end else begin
      state <= state_next;
      if (phase_load) begin
        phase <= phase_next;
      end
    end
  end

  // output register decouples the receiver from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= scale_cmp;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_div_done_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_MOD || state == ST_IDX))
    else $error("divider finished outside a divide state");

  a_scale_done_owned: assert property (@(posedge clk) disable iff (rst)
    scale_done |-> (state == ST_SCALE))
    else $error("scaler finished outside scale state");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCALE || state == ST_IDX)
      && (effect_mode == MODE_BREATH || effect_mode == MODE_FLASH))
      |-> (phase < period))
    else $error("phase not wrapped below period");

  a_phase_parked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE && (effect_mode == MODE_OFF || effect_mode == MODE_STATIC))
      |-> (phase == '0))
    else $error("phase not cleared in off or static mode");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_SCALE || state == ST_HOLD))
    else $error("output raised without a finished result");

endmodule

`default_nettype wire
